// ===== rtl/bfx_pkg.sv =====
// Shared types and constants for the Brainfuck execute core.
// No dependencies; used by the core datapath and the top level.
package bfx_pkg;

  // Request kinds carried by the input transfer
  localparam logic REQ_RESTART = 1'b0;
  localparam logic REQ_EXEC    = 1'b1;

  // Program characters that act
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;

  // Skip nesting counter width and its ceiling
  localparam int unsigned SKIP_W = 5;
  localparam logic [SKIP_W-1:0] SKIP_LIMIT = 5'd31;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_STACK = 2'd1,
    ERR_SKIP  = 2'd2
  } bfx_err_t;

  // Item handed to the core when the input stage advances
  typedef struct packed {
    logic       fire;
    logic       req_type;
    logic [7:0] instr_byte;
  } bfx_step_t;

  // Result fields other than the fetch address
  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       halted;
    bfx_err_t   error_code;
  } bfx_res_t;

endpackage

// ===== rtl/bfx_if.sv =====
// Valid/ready channel interfaces for the Brainfuck execute core.
// Depends on nothing; address width set by ADDR_W.
interface bfx_in_if #(parameter int ADDR_W = 10);
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ADDR_W-1:0] instr_addr;
  logic [7:0]        instr_byte;

  modport source (output valid, req_type, instr_addr, instr_byte, input ready);
  modport sink   (input valid, req_type, instr_addr, instr_byte, output ready);
endinterface

interface bfx_out_if #(parameter int ADDR_W = 10);
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] next_addr;
  logic              out_valid;
  logic [7:0]        out_byte;
  logic              halted;
  logic [1:0]        error_code;

  modport source (output valid, next_addr, out_valid, out_byte, halted, error_code,
                  input ready);
  modport sink   (input valid, next_addr, out_valid, out_byte, halted, error_code,
                  output ready);
endinterface

// ===== rtl/brainfuck_execute_core_unit.sv =====
// Top level of the Brainfuck execute core: input stage, result stage, handshakes.
// Depends on bfx_pkg, bfx_if (bfx_in_if, bfx_out_if) and bfx_core.
//
//   channel   dir  payload                                          transfer
//   in_chan   in   req_type, instr_addr, instr_byte                 valid & ready
//   out_chan  out  next_addr, out_valid, out_byte, halted, error_code valid & ready
//
// One instruction per cycle while out_chan is not stalled: an item is registered in
// the input stage, decoded against the interpreter state and registered in the
// result stage; the rate is set by the combinational step in bfx_core.
// rst_n (synchronous) clears cells, pointer, stack level, skip count and halt.
// A stalled result holds the result stage; the input stage still fills behind it.
module brainfuck_execute_core_unit #(
  parameter int CELL_COUNT = 16,
  parameter int PROG_DEPTH = 1024,
  parameter int LOOP_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  bfx_in_if.sink     in_chan,
  bfx_out_if.source  out_chan
);

  localparam int AW = $clog2(PROG_DEPTH);

  logic              s1_v_r;
  logic              s1_req_r;
  logic [AW-1:0]     s1_addr_r;
  logic [7:0]        s1_byte_r;
  logic              o_v_r;
  logic [AW-1:0]     o_addr_r;
  bfx_pkg::bfx_res_t o_res_r;

  logic              adv;
  bfx_pkg::bfx_step_t step;
  logic [AW-1:0]     core_addr;
  bfx_pkg::bfx_res_t core_res;

  // Input stage moves on when the result stage is free or draining
  assign adv           = s1_v_r && (!o_v_r || out_chan.ready);
  assign in_chan.ready = !s1_v_r || adv;

  assign step.fire       = adv;
  assign step.req_type   = s1_req_r;
  assign step.instr_byte = s1_byte_r;

  bfx_core #(
    .CELL_COUNT (CELL_COUNT),
    .PROG_DEPTH (PROG_DEPTH),
    .LOOP_DEPTH (LOOP_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .instr_addr (s1_addr_r),
    .next_addr  (core_addr),
    .res        (core_res)
  );

  // Input stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_v_r <= in_chan.valid;
    end
  end

  // Capture the input payload on each input transfer
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_req_r  <= in_chan.req_type;
      s1_addr_r <= in_chan.instr_addr;
      s1_byte_r <= in_chan.instr_byte;
    end
  end

  // Result stage valid: set on advance, drop on output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (adv) begin
      o_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      o_v_r <= 1'b0;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (adv) begin
      o_addr_r <= core_addr;
      o_res_r  <= core_res;
    end
  end

  assign out_chan.valid      = o_v_r;
  assign out_chan.next_addr  = o_addr_r;
  assign out_chan.out_valid  = o_res_r.out_valid;
  assign out_chan.out_byte   = o_res_r.out_byte;
  assign out_chan.halted     = o_res_r.halted;
  assign out_chan.error_code = o_res_r.error_code;

endmodule

// ===== rtl/bfx_core.sv =====
// Interpreter state (cells, pointer, loop stack, skip counter, halt) and the
// combinational step logic. Depends on bfx_pkg.
module bfx_core #(
  parameter int CELL_COUNT = 16,
  parameter int PROG_DEPTH = 1024,
  parameter int LOOP_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bfx_pkg::bfx_step_t            step,
  input  logic [$clog2(PROG_DEPTH)-1:0] instr_addr,
  output logic [$clog2(PROG_DEPTH)-1:0] next_addr,
  output bfx_pkg::bfx_res_t             res
);

  localparam int AW  = $clog2(PROG_DEPTH);
  localparam int DPW = $clog2(CELL_COUNT);
  localparam int SW  = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
  localparam int LW  = $clog2(LOOP_DEPTH + 1);

  localparam logic [AW:0]    PROG_END  = (AW+1)'(PROG_DEPTH);
  localparam logic [AW-1:0]  PROG_LAST = AW'(PROG_DEPTH - 1);
  localparam logic [DPW-1:0] DP_LAST   = DPW'(CELL_COUNT - 1);
  localparam logic [LW-1:0]  LVL_FULL  = LW'(LOOP_DEPTH);

  logic [7:0]             cells_r [CELL_COUNT];
  logic [AW-1:0]          stack_r [LOOP_DEPTH];
  logic [DPW-1:0]         dp_r, dp_nxt;
  logic [LW-1:0]          level_r, level_nxt;
  logic [bfx_pkg::SKIP_W-1:0] skip_r, skip_nxt;
  logic                   halt_r, halt_nxt;
  bfx_pkg::bfx_err_t      err_r, err_nxt;

  logic [AW-1:0] addr_m, addr_inc, top, top_inc;
  logic [LW-1:0] level_dec;
  logic [7:0]    cur;
  logic          cell_we, push_we, restart;
  logic [7:0]    cell_wd;

  // Reduce the fetch address into the program and form its successor
  assign addr_m   = ({1'b0, instr_addr} >= PROG_END) ?
                    AW'({1'b0, instr_addr} - PROG_END) : instr_addr;
  assign addr_inc = (addr_m == PROG_LAST) ? '0 : addr_m + 1'b1;

  // Current cell and top of the loop stack
  assign cur       = cells_r[dp_r];
  assign level_dec = level_r - 1'b1;
  assign top       = stack_r[level_dec[SW-1:0]];
  assign top_inc   = (top == PROG_LAST) ? '0 : top + 1'b1;
  assign restart   = (step.req_type == bfx_pkg::REQ_RESTART);

  // Decode one instruction against the current state
  always_comb begin
    halt_nxt  = halt_r;
    err_nxt   = err_r;
    dp_nxt    = dp_r;
    level_nxt = level_r;
    skip_nxt  = skip_r;
    cell_we   = 1'b0;
    cell_wd   = cur;
    push_we   = 1'b0;
    next_addr = addr_inc;
    res       = '0;
    if (restart) begin
      halt_nxt  = 1'b0;
      err_nxt   = bfx_pkg::ERR_NONE;
      dp_nxt    = '0;
      level_nxt = '0;
      skip_nxt  = '0;
      next_addr = '0;
    end else if (halt_r) begin
      next_addr = addr_m;
    end else if (skip_r != '0) begin
      case (step.instr_byte)
        bfx_pkg::CH_NUL: begin
          halt_nxt  = 1'b1;
          err_nxt   = bfx_pkg::ERR_NONE;
          next_addr = addr_m;
        end
        bfx_pkg::CH_LBR: begin
          if (skip_r >= bfx_pkg::SKIP_LIMIT) begin
            halt_nxt  = 1'b1;
            err_nxt   = bfx_pkg::ERR_SKIP;
            next_addr = addr_m;
          end else begin
            skip_nxt = skip_r + 1'b1;
          end
        end
        bfx_pkg::CH_RBR: skip_nxt = skip_r - 1'b1;
        default: ;
      endcase
    end else begin
      case (step.instr_byte)
        bfx_pkg::CH_NUL: begin
          halt_nxt  = 1'b1;
          err_nxt   = bfx_pkg::ERR_NONE;
          next_addr = addr_m;
        end
        bfx_pkg::CH_PLUS: begin
          cell_we = 1'b1;
          cell_wd = cur + 8'd1;
        end
        bfx_pkg::CH_MINUS: begin
          cell_we = 1'b1;
          cell_wd = cur - 8'd1;
        end
        bfx_pkg::CH_DOT: begin
          res.out_valid = 1'b1;
          res.out_byte  = cur;
        end
        bfx_pkg::CH_GT: dp_nxt = (dp_r == DP_LAST) ? '0 : dp_r + 1'b1;
        bfx_pkg::CH_LT: dp_nxt = (dp_r == '0) ? DP_LAST : dp_r - 1'b1;
        bfx_pkg::CH_LBR: begin
          if (cur == 8'd0) begin
            skip_nxt = bfx_pkg::SKIP_W'(1);
          end else if (level_r >= LVL_FULL) begin
            halt_nxt  = 1'b1;
            err_nxt   = bfx_pkg::ERR_STACK;
            next_addr = addr_m;
          end else begin
            push_we   = 1'b1;
            level_nxt = level_r + 1'b1;
          end
        end
        bfx_pkg::CH_RBR: begin
          if (level_r == '0) begin
            halt_nxt  = 1'b1;
            err_nxt   = bfx_pkg::ERR_NONE;
            next_addr = addr_m;
          end else if (cur != 8'd0) begin
            next_addr = top_inc;
          end else begin
            level_nxt = level_dec;
          end
        end
        default: ;
      endcase
    end
    res.halted     = halt_nxt;
    res.error_code = err_nxt;
  end

  // Control state: advance on each transfer out of the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_r    <= '0;
      level_r <= '0;
      skip_r  <= '0;
      halt_r  <= 1'b0;
      err_r   <= bfx_pkg::ERR_NONE;
    end else if (step.fire) begin
      dp_r    <= dp_nxt;
      level_r <= level_nxt;
      skip_r  <= skip_nxt;
      halt_r  <= halt_nxt;
      err_r   <= err_nxt;
    end
  end

  // Cell store: cleared by reset and by restart
  always_ff @(posedge clk) begin
    if (!rst_n || (step.fire && restart)) begin
      for (int i = 0; i < CELL_COUNT; i++) begin
        cells_r[i] <= 8'd0;
      end
    end else if (step.fire && cell_we) begin
      cells_r[dp_r] <= cell_wd;
    end
  end

  // Loop stack: push the address of an entered loop
  always_ff @(posedge clk) begin
    if (step.fire && !restart && push_we) begin
      stack_r[level_r[SW-1:0]] <= addr_m;
    end
  end

endmodule
